/* hw/rtl/sankoff_parsimony_tree_scorer_top_assert.svh */
// Assertion macros shared by the scorer's RTL.
`ifndef SANKOFF_PARSIMONY_TREE_SCORER_TOP_ASSERT_SVH
`define SANKOFF_PARSIMONY_TREE_SCORER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The condition must never be true.
`define SPTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/spts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spts_pkg
// Shared types and constants of the parsimony tree scorer.
// ----------------------------------------------------------------------------
package spts_pkg;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_HEADER = 3'd1,
    REQ_OPEN   = 3'd2,
    REQ_LEAF   = 3'd3,
    REQ_CLOSE  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MASK     = 3'd1,
    ERR_COUNTS   = 3'd2,
    ERR_STACK    = 3'd3,
    ERR_STRUCT   = 3'd4,
    ERR_OVERFLOW = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    EV_CLEAR,
    EV_HEADER,
    EV_OPEN,
    EV_LEAF,
    EV_CLOSE
  } ev_kind_t;

  typedef enum logic {
    TK_CLEAR,
    TK_ROOT
  } tok_kind_t;

  typedef enum logic {
    CFG_EDGE_MODE = 1'b0,
    CFG_OFFSET    = 1'b1
  } cfg_idx_t;

  localparam int unsigned STATES      = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0]  MASK_HIGH   = 8'hF0;

  // Decoded event handed from the front end to the stack engine.
  typedef struct packed {
    ev_kind_t               kind;
    logic [STATES-1:0]      leaf_bits;
    logic                   mask_bad;
    logic                   hdr_bad;
    logic [31:0]            weight;
    logic [STATES-1:0][31:0] counts;
  } ev_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      new_epoch;
    err_t      err;
  } meta_t;

  // Root completion or total clear handed to the scoring pipeline.
  typedef struct packed {
    meta_t                   meta;
    logic [31:0]             weight;
    logic [STATES-1:0][31:0] counts;
  } tok_t;

endpackage

/* hw/rtl/spts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spts_front
// Input stage: takes transfers, decodes the request and checks masks and
// header counts, and holds one decoded event for the queue.
// ----------------------------------------------------------------------------
module spts_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [2:0]      in_tuser,
  input  logic [167:0]    in_tdata,
  output spts_pkg::ev_t   ev_o,
  output logic            ev_valid_o,
  input  logic            ev_ready_i
);

  spts_pkg::ev_t ev_r, ev_nxt;
  logic          ev_v_r;
  logic          known;
  logic [33:0]   count_sum;
  logic [7:0]    mask;

  assign in_tready  = !ev_v_r || ev_ready_i;
  assign ev_o       = ev_r;
  assign ev_valid_o = ev_v_r;
  assign mask       = in_tdata[7:0];

  always_comb begin
    ev_nxt.leaf_bits = mask[3:0];
    ev_nxt.mask_bad  = (mask == 8'd0) || ((mask & spts_pkg::MASK_HIGH) != 8'd0);
    ev_nxt.weight    = in_tdata[39:8];
    count_sum        = 34'd0;
    for (int s = 0; s < spts_pkg::STATES; s++) begin
      ev_nxt.counts[s] = in_tdata[40 + 32*s +: 32];
      count_sum        = count_sum + {2'b00, in_tdata[40 + 32*s +: 32]};
    end
    ev_nxt.hdr_bad = (in_tdata[39:8] == 32'd0) || (count_sum != {2'b00, in_tdata[39:8]});
    known          = 1'b1;
    case (in_tuser)
      spts_pkg::REQ_CLEAR:  ev_nxt.kind = spts_pkg::EV_CLEAR;
      spts_pkg::REQ_HEADER: ev_nxt.kind = spts_pkg::EV_HEADER;
      spts_pkg::REQ_OPEN:   ev_nxt.kind = spts_pkg::EV_OPEN;
      spts_pkg::REQ_LEAF:   ev_nxt.kind = spts_pkg::EV_LEAF;
      spts_pkg::REQ_CLOSE:  ev_nxt.kind = spts_pkg::EV_CLOSE;
      default: begin
        ev_nxt.kind = spts_pkg::EV_CLEAR;
        known       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      ev_v_r <= known;
    end else if (ev_ready_i) begin
      ev_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ev_r <= ev_nxt;
    end
  end

endmodule

/* hw/rtl/spts_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spts_fifo
// Short event queue between the front end and the stack engine.
// ----------------------------------------------------------------------------
module spts_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  spts_pkg::ev_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output spts_pkg::ev_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned PW = $clog2(spts_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(spts_pkg::QUEUE_DEPTH + 1);

  spts_pkg::ev_t entries_r [spts_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full_o     = (count_r == CW'(spts_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_r == '0);
  assign pop_data_o = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_i)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) entries_r[wr_ptr_r] <= push_data_i;
  end

endmodule

/* hw/rtl/spts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spts_back
// Stack engine: keeps the top cost row in registers and the rows below it
// in a memory whose read port always has the next row down ready.
// ----------------------------------------------------------------------------
module spts_back #(
  parameter int unsigned MAX_DEPTH  = 64,
  parameter int unsigned COST_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  spts_pkg::ev_t                           ev_i,
  input  logic                                    ev_valid_i,
  output logic                                    ev_pop_o,
  input  logic                                    adv_i,
  output logic                                    tok_valid_o,
  output spts_pkg::tok_t                          tok_o,
  output logic [spts_pkg::STATES-1:0][COST_WIDTH-1:0] root_o
);

  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

  typedef logic [spts_pkg::STATES-1:0][COST_WIDTH-1:0] row_t;

  row_t              mem [MAX_DEPTH];
  row_t              top_r, top_nxt, rd_r;
  row_t              leaf_row, fold_par, fold_ch, fold_out;
  logic              fold_ovf;
  logic [LW-1:0]     level_r, level_nxt;
  logic [LW-1:0]     level_m1, level_m3;
  spts_pkg::err_t    err_r, err_nxt;
  logic [31:0]       weight_r, weight_nxt;
  logic [spts_pkg::STATES-1:0][31:0] counts_r, counts_nxt;
  logic              pend_r, pend_nxt;
  logic              tok_v_r, tok_v_nxt;
  spts_pkg::tok_t    tok_r, tok_nxt;
  row_t              root_r, root_nxt;
  logic              do_push, rd_from_mem;
  logic [COST_WIDTH:0]   best, cand;
  logic [COST_WIDTH+1:0] total;

  assign ev_pop_o    = ev_valid_i && adv_i;
  assign tok_valid_o = tok_v_r;
  assign tok_o       = tok_r;
  assign root_o      = root_r;
  assign level_m1    = level_r - LW'(1);
  assign level_m3    = level_r - LW'(3);

  always_comb begin
    for (int s = 0; s < spts_pkg::STATES; s++) begin
      leaf_row[s] = COST_WIDTH'(!ev_i.leaf_bits[s]);
    end
  end

  // One fold unit: leaf folds into the top row, close folds top into below.
  always_comb begin
    fold_par = (ev_i.kind == spts_pkg::EV_LEAF) ? top_r : rd_r;
    fold_ch  = (ev_i.kind == spts_pkg::EV_LEAF) ? leaf_row : top_r;
    fold_ovf = 1'b0;
    for (int p = 0; p < spts_pkg::STATES; p++) begin
      best = {1'b0, fold_ch[p]};
      for (int c = 0; c < spts_pkg::STATES; c++) begin
        cand = {1'b0, fold_ch[c]} + (COST_WIDTH+1)'(1);
        if (c != p && cand < best) best = cand;
      end
      total = {2'b00, fold_par[p]} + {1'b0, best};
      if (total > {2'b00, COST_MAX}) begin
        fold_out[p] = COST_MAX;
        fold_ovf    = 1'b1;
      end else begin
        fold_out[p] = total[COST_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    level_nxt   = level_r;
    top_nxt     = top_r;
    err_nxt     = err_r;
    weight_nxt  = weight_r;
    counts_nxt  = counts_r;
    pend_nxt    = pend_r;
    tok_v_nxt   = 1'b0;
    tok_nxt     = tok_r;
    root_nxt    = root_r;
    do_push     = 1'b0;
    rd_from_mem = 1'b0;
    tok_nxt.meta.kind      = spts_pkg::TK_ROOT;
    tok_nxt.meta.new_epoch = pend_r;
    tok_nxt.weight         = weight_r;
    tok_nxt.counts         = counts_r;
    if (ev_pop_o) begin
      case (ev_i.kind)
        spts_pkg::EV_CLEAR: begin
          level_nxt         = '0;
          err_nxt           = spts_pkg::ERR_NONE;
          tok_v_nxt         = 1'b1;
          tok_nxt.meta.kind = spts_pkg::TK_CLEAR;
        end
        spts_pkg::EV_HEADER: begin
          level_nxt  = '0;
          err_nxt    = ev_i.hdr_bad ? spts_pkg::ERR_COUNTS : spts_pkg::ERR_NONE;
          weight_nxt = ev_i.weight;
          counts_nxt = ev_i.counts;
          pend_nxt   = 1'b1;
        end
        spts_pkg::EV_OPEN: begin
          if (level_r == LW'(MAX_DEPTH)) begin
            if (err_r == spts_pkg::ERR_NONE) err_nxt = spts_pkg::ERR_STACK;
          end else begin
            do_push   = 1'b1;
            level_nxt = level_r + LW'(1);
            top_nxt   = '0;
          end
        end
        spts_pkg::EV_LEAF: begin
          if (ev_i.mask_bad && err_nxt == spts_pkg::ERR_NONE) err_nxt = spts_pkg::ERR_MASK;
          if (level_r != '0) begin
            top_nxt = fold_out;
            if (fold_ovf && err_nxt == spts_pkg::ERR_NONE) err_nxt = spts_pkg::ERR_OVERFLOW;
          end else begin
            tok_v_nxt        = 1'b1;
            tok_nxt.meta.err = err_nxt;
            root_nxt         = leaf_row;
            pend_nxt         = 1'b0;
          end
        end
        spts_pkg::EV_CLOSE: begin
          if (level_r == '0) begin
            if (err_r == spts_pkg::ERR_NONE) err_nxt = spts_pkg::ERR_STRUCT;
          end else begin
            level_nxt = level_m1;
            if (level_r >= LW'(2)) begin
              top_nxt     = fold_out;
              rd_from_mem = (level_r >= LW'(3));
              if (fold_ovf && err_r == spts_pkg::ERR_NONE) err_nxt = spts_pkg::ERR_OVERFLOW;
            end else begin
              tok_v_nxt        = 1'b1;
              tok_nxt.meta.err = err_r;
              root_nxt         = top_r;
              pend_nxt         = 1'b0;
            end
          end
        end
        default: begin
          level_nxt = level_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      err_r    <= spts_pkg::ERR_NONE;
      weight_r <= '0;
      counts_r <= '0;
      pend_r   <= 1'b0;
      tok_v_r  <= 1'b0;
    end else if (adv_i) begin
      level_r  <= level_nxt;
      err_r    <= err_nxt;
      weight_r <= weight_nxt;
      counts_r <= counts_nxt;
      pend_r   <= pend_nxt;
      tok_v_r  <= tok_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      top_r  <= top_nxt;
      tok_r  <= tok_nxt;
      root_r <= root_nxt;
    end
  end

  // The row under the top is always held in rd_r.
  always_ff @(posedge clk) begin
    if (do_push && level_r != '0) begin
      mem[level_m1[AW-1:0]] <= top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && level_r != '0) begin
      rd_r <= top_r;
    end else if (rd_from_mem) begin
      rd_r <= mem[level_m3[AW-1:0]];
    end
  end

endmodule

/* hw/rtl/spts_score.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spts_score
// Scoring pipeline: root minima, weight or count products, saturating sum,
// running total and the output register.
// ----------------------------------------------------------------------------
module spts_score #(
  parameter int unsigned COST_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        tok_valid_i,
  input  spts_pkg::tok_t                              tok_i,
  input  logic [spts_pkg::STATES-1:0][COST_WIDTH-1:0] root_i,
  output logic                                        adv_o,
  input  logic                                        edge_mode_i,
  input  logic [63:0]                                 offset_i,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [135:0]                                out_tdata
);

  localparam int unsigned ST = spts_pkg::STATES;

  logic                     a_v_r, b_v_r, c_v_r, d_v_r, out_v_r;
  spts_pkg::meta_t          a_meta_r, b_meta_r, c_meta_r, d_meta_r;
  logic [ST-1:0][31:0]      opa_r, opb_r, opa_nxt, opb_nxt;
  logic [ST-1:0][63:0]      prod_r;
  logic [64:0]              s01_r, s23_r;
  logic [65:0]              sum_all;
  logic [63:0]              site_r, site_nxt;
  logic                     site_ovf_r, site_ovf_nxt;
  logic [63:0]              total_r, total_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [64:0]              acc;
  spts_pkg::err_t           eff;
  logic [63:0]              out_site_r, out_total_r, out_site_nxt;
  spts_pkg::err_t           out_err_r;
  logic [COST_WIDTH:0]      best, cand;
  logic [COST_WIDTH-1:0]    mn;

  assign adv_o      = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_err_r, out_total_r, out_site_r};

  // Stage A operands: minimum times weight, or per reference state the
  // edge minimum times its count.
  always_comb begin
    mn = root_i[0];
    for (int s = 1; s < ST; s++) begin
      if (root_i[s] < mn) mn = root_i[s];
    end
    for (int r = 0; r < ST; r++) begin
      best = {1'b0, root_i[r]};
      for (int c = 0; c < ST; c++) begin
        cand = {1'b0, root_i[c]} + (COST_WIDTH+1)'(1);
        if (c != r && cand < best) best = cand;
      end
      if (edge_mode_i) begin
        opa_nxt[r] = 32'(best[COST_WIDTH-1:0]);
        opb_nxt[r] = tok_i.counts[r];
      end else begin
        opa_nxt[r] = (r == 0) ? 32'(mn) : 32'd0;
        opb_nxt[r] = (r == 0) ? tok_i.weight : 32'd0;
      end
    end
  end

  always_comb begin
    sum_all      = {1'b0, s01_r} + {1'b0, s23_r};
    site_ovf_nxt = (sum_all[65:64] != 2'b00);
    site_nxt     = site_ovf_nxt ? '1 : sum_all[63:0];
  end

  always_comb begin
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;
    out_site_nxt = site_r;
    eff          = spts_pkg::ERR_NONE;
    acc          = {1'b0, total_r} + {1'b0, site_r};
    if (d_v_r) begin
      if (d_meta_r.kind == spts_pkg::TK_CLEAR) begin
        total_nxt = edge_mode_i ? offset_i : 64'd0;
        ovf_nxt   = 1'b0;
      end else begin
        if (ovf_r && !d_meta_r.new_epoch) begin
          eff = spts_pkg::ERR_OVERFLOW;
        end else begin
          eff = d_meta_r.err;
        end
        if (eff == spts_pkg::ERR_NONE && (site_ovf_r || acc[64])) begin
          eff = spts_pkg::ERR_OVERFLOW;
        end
        if (eff != spts_pkg::ERR_NONE) begin
          total_nxt    = '1;
          out_site_nxt = '1;
        end else begin
          total_nxt = acc[63:0];
        end
        ovf_nxt = (eff == spts_pkg::ERR_OVERFLOW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else if (adv_o) begin
      a_v_r   <= tok_valid_i;
      b_v_r   <= a_v_r;
      c_v_r   <= b_v_r;
      d_v_r   <= c_v_r;
      out_v_r <= d_v_r && (d_meta_r.kind == spts_pkg::TK_ROOT);
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      a_meta_r <= tok_i.meta;
      opa_r    <= opa_nxt;
      opb_r    <= opb_nxt;
      b_meta_r <= a_meta_r;
      for (int s = 0; s < ST; s++) begin
        prod_r[s] <= opa_r[s] * opb_r[s];
      end
      c_meta_r    <= b_meta_r;
      s01_r       <= {1'b0, prod_r[0]} + {1'b0, prod_r[1]};
      s23_r       <= {1'b0, prod_r[2]} + {1'b0, prod_r[3]};
      d_meta_r    <= c_meta_r;
      site_r      <= site_nxt;
      site_ovf_r  <= site_ovf_nxt;
      out_site_r  <= out_site_nxt;
      out_total_r <= total_nxt;
      out_err_r   <= eff;
    end
  end

endmodule

/* hw/rtl/sankoff_parsimony_tree_scorer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sankoff_parsimony_tree_scorer_top
// Unit-cost four-state parsimony scorer over preorder tree event streams.
// ----------------------------------------------------------------------------
// The block takes one tree event per clock cycle while the queue is not
// full: an input register decodes it into a four-entry queue, and the stack
// engine executes one event per cycle unless stalled, since each event touches
// only the top row (held in registers) and the row below it (kept ready by
// the stack memory's registered read port). A completed root travels a
// five-stage scoring pipeline (minima, products, two sum stages, total and
// output register) before out_tvalid rises. Results leave through a
// registered output; back-pressure on it stalls the engine while the queue
// keeps taking input until it fills.
module sankoff_parsimony_tree_scorer_top #(
  parameter int unsigned MAX_DEPTH  = 64,
  parameter int unsigned COST_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // req_type
  // leaf_mask, pattern_weight, count_a, count_c, count_g, count_t
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // site_score, running_total, error_code, zero pad
  output logic [135:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata
);

  spts_pkg::ev_t  fe_ev, q_ev;
  logic           fe_valid;
  logic           q_push, q_pop, q_full, q_empty;
  logic           adv;
  logic           tok_valid;
  spts_pkg::tok_t tok;
  logic [spts_pkg::STATES-1:0][COST_WIDTH-1:0] root;
  logic           edge_mode_r;
  logic [63:0]    offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_mode_r <= 1'b0;
      offset_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spts_pkg::CFG_EDGE_MODE: edge_mode_r <= cfg_wdata[0];
        spts_pkg::CFG_OFFSET:    offset_r    <= cfg_wdata;
        default:                 offset_r    <= offset_r;
      endcase
    end
  end

  assign q_push = fe_valid && !q_full;

  spts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .ev_o       (fe_ev),
    .ev_valid_o (fe_valid),
    .ev_ready_i (!q_full)
  );

  spts_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (fe_ev),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_ev),
    .empty_o     (q_empty)
  );

  spts_back #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COST_WIDTH (COST_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_i        (q_ev),
    .ev_valid_i  (!q_empty),
    .ev_pop_o    (q_pop),
    .adv_i       (adv),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .root_o      (root)
  );

  spts_score #(
    .COST_WIDTH (COST_WIDTH)
  ) u_score (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .root_i      (root),
    .adv_o       (adv),
    .edge_mode_i (edge_mode_r),
    .offset_i    (offset_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

`include "sankoff_parsimony_tree_scorer_top_assert.svh"

  `SPTS_ASSERT_NEVER(a_queue_overrun, q_push && q_full && !q_pop, "event queue overrun")
  `SPTS_ASSERT_IMPL(a_queue_underrun, q_pop, !q_empty, "event queue underrun")
  `SPTS_ASSERT_IMPL(a_err_saturates, out_tvalid && out_tdata[130:128] != spts_pkg::ERR_NONE, out_tdata[127:0] == {128{1'b1}}, "errored result not saturated")

endmodule

/* dv/sankoff_parsimony_tree_scorer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sankoff_parsimony_tree_scorer_top_tb
// Self-checking bench for the parsimony tree scorer. Preorder event streams
// (headers, open, leaf and close events, clears and malformed traffic) go
// into the block. A scoreboard predicts every root result and compares it
// field by field with the output stream, under random idling on both sides
// and several register settings.
// ----------------------------------------------------------------------------
module sankoff_parsimony_tree_scorer_top_tb;

  localparam int          DEPTH           = 64;
  localparam logic [63:0] COST_CEIL       = 64'd65535;
  localparam logic [2:0]  REQ_UNUSED      = 3'd5;
  localparam logic [2:0]  REQ_UNUSED_LAST = 3'd7;
  localparam int          STALL_LIMIT     = 20000;

  typedef logic [63:0] cost_row_t [4];

  typedef struct {
    logic [63:0] site;
    logic [63:0] total;
    logic [2:0]  err;
  } score_t;

  class parsimony_scoreboard;
    cost_row_t        rows [DEPTH];
    int unsigned      level;
    logic [63:0]      total;
    logic [31:0]      weight;
    logic [31:0]      counts [4];
    spts_pkg::err_t   err_held;
    logic             edge_mode;
    logic [63:0]      offset;
    score_t           pending [$];
    int               fails;

    function void latch(spts_pkg::err_t c);
      if (err_held == spts_pkg::ERR_NONE) err_held = c;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      if (b > ~a) begin
        latch(spts_pkg::ERR_OVERFLOW);
        return '1;
      end
      return a + b;
    endfunction

    function logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      if (p[127:64] != 0) begin
        latch(spts_pkg::ERR_OVERFLOW);
        return '1;
      end
      return p[63:0];
    endfunction

    function logic [63:0] edge_cost(cost_row_t r, int to);
      logic [63:0] best;
      best = '1;
      for (int s = 0; s < 4; s++)
        if (r[s] + (s != to) < best) best = r[s] + (s != to);
      return best;
    endfunction

    function void fold(cost_row_t child);
      logic [63:0] v;
      for (int p = 0; p < 4; p++) begin
        v = rows[level-1][p] + edge_cost(child, p);
        if (v > COST_CEIL) begin
          latch(spts_pkg::ERR_OVERFLOW);
          v = COST_CEIL;
        end
        rows[level-1][p] = v;
      end
    endfunction

    function void finish(cost_row_t root);
      score_t      r;
      logic [63:0] best;
      r.site = 0;
      if (!edge_mode) begin
        best = '1;
        for (int s = 0; s < 4; s++)
          if (root[s] < best) best = root[s];
        r.site = mul_sat(best, weight);
      end else begin
        for (int s = 0; s < 4; s++)
          if (counts[s] != 0) r.site = add_sat(r.site, mul_sat(edge_cost(root, s), counts[s]));
      end
      if (err_held == spts_pkg::ERR_NONE) total = add_sat(total, r.site);
      if (err_held != spts_pkg::ERR_NONE) begin
        r.site = '1;
        total  = '1;
      end
      r.total = total;
      r.err   = err_held;
      pending.insert(pending.size(), r);
    endfunction

    function void reset_state();
      level     = 0;
      total     = 0;
      weight    = 0;
      counts    = '{default: 0};
      err_held  = spts_pkg::ERR_NONE;
      edge_mode = 0;
      offset    = 0;
      fails     = 0;
    endfunction

    function void write_reg(spts_pkg::cfg_idx_t idx, logic [63:0] v);
      if (idx == spts_pkg::CFG_EDGE_MODE) edge_mode = v[0];
      else offset = v;
    endfunction

    function void note_event(logic [2:0] kind, logic [7:0] mask, logic [31:0] w,
                             logic [31:0] c [4]);
      cost_row_t   r;
      logic [33:0] sum;
      case (kind)
        spts_pkg::REQ_CLEAR: begin
          total    = edge_mode ? offset : 64'd0;
          level    = 0;
          err_held = spts_pkg::ERR_NONE;
        end
        spts_pkg::REQ_HEADER: begin
          level    = 0;
          err_held = spts_pkg::ERR_NONE;
          weight   = w;
          counts   = c;
          sum      = 0;
          for (int s = 0; s < 4; s++) sum += {2'b00, c[s]};
          if (w == 0 || sum != {2'b00, w}) latch(spts_pkg::ERR_COUNTS);
        end
        spts_pkg::REQ_OPEN: begin
          if (level >= DEPTH) latch(spts_pkg::ERR_STACK);
          else begin
            rows[level] = '{default: 0};
            level++;
          end
        end
        spts_pkg::REQ_LEAF: begin
          if (mask == 0 || (mask & spts_pkg::MASK_HIGH) != 0) latch(spts_pkg::ERR_MASK);
          for (int s = 0; s < 4; s++) r[s] = mask[s] ? 64'd0 : 64'd1;
          if (level > 0) fold(r);
          else finish(r);
        end
        spts_pkg::REQ_CLOSE: begin
          if (level == 0) latch(spts_pkg::ERR_STRUCT);
          else begin
            level--;
            r = rows[level];
            if (level > 0) fold(r);
            else finish(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check(logic [135:0] d);
      score_t e;
      if (pending.size() == 0) begin
        $error("result with no expectation: site_score %0h", d[63:0]);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e.site) begin
        $error("site_score expected %0h actual %0h", e.site, d[63:0]);
        fails++;
      end
      if (d[127:64] !== e.total) begin
        $error("running_total expected %0h actual %0h", e.total, d[127:64]);
        fails++;
      end
      if (d[130:128] !== e.err) begin
        $error("error_code expected %0d actual %0d", e.err, d[130:128]);
        fails++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_tvalid = 0;
  logic               in_tready;
  logic [2:0]         in_tuser = 0;   // req_type
  // leaf_mask, pattern_weight, count_a, count_c, count_g, count_t
  logic [167:0]       in_tdata = 0;
  logic               out_tvalid;
  logic               out_tready = 0;
  // site_score, running_total, error_code, zero pad
  logic [135:0]       out_tdata;
  logic               cfg_we = 0;
  spts_pkg::cfg_idx_t cfg_index = spts_pkg::CFG_EDGE_MODE;
  logic [63:0]        cfg_wdata = 0;

  parsimony_scoreboard sb = new();
  logic sender_idles = 0;
  logic receiver_stalls = 0;
  int   idle_pct = 59;
  int   hold_off = 0;
  int   quiet_cycles = 0;
  int   sent = 0;

  sankoff_parsimony_tree_scorer_top dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off   <= hold_off - 1;
    end else begin
      out_tready <= receiver_stalls ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic [2:0] kind, logic [7:0] mask, logic [31:0] w,
                      logic [31:0] c [4]);
    if (sender_idles && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {c[3], c[2], c[1], c[0], w, mask};
    do @(posedge clk); while (!in_tready);
    sb.note_event(kind, mask, w, c);
    sent++;
  endtask

  task automatic event_only(logic [2:0] kind, logic [7:0] mask);
    logic [31:0] c [4];
    c = '{$urandom, $urandom, $urandom, $urandom};
    send(kind, mask, $urandom, c);
  endtask

  task automatic header(logic [31:0] c [4]);
    send(spts_pkg::REQ_HEADER, 8'($urandom), c[0] + c[1] + c[2] + c[3], c);
  endtask

  task automatic random_header();
    logic [31:0] c [4];
    int pick;
    pick = $urandom_range(9);
    for (int s = 0; s < 4; s++) c[s] = $urandom_range(20);
    if (pick == 0) begin
      c = '{0, 0, 0, 0};
      c[$urandom_range(3)] = $urandom;
    end else if (pick == 1) begin
      for (int s = 0; s < 4; s++) c[s] = $urandom >> 2;
    end
    header(c);
  endtask

  task automatic subtree(int d, int max_d);
    if (d >= max_d || $urandom_range(2) == 0) begin
      event_only(spts_pkg::REQ_LEAF, 8'($urandom_range(1, 15)));
    end else begin
      event_only(spts_pkg::REQ_OPEN, 8'($urandom));
      repeat ($urandom_range(1, 3)) subtree(d + 1, max_d);
      event_only(spts_pkg::REQ_CLOSE, 8'($urandom));
    end
  endtask

  // Mostly well-formed patterns; the rest is malformed or unusual traffic.
  task automatic random_traffic(int n);
    int target;
    logic [31:0] c [4];
    target = sent + n;
    while (sent < target) begin
      case ($urandom_range(19))
        0: event_only(spts_pkg::REQ_CLEAR, 8'($urandom));
        1: event_only(3'($urandom_range(REQ_UNUSED, REQ_UNUSED_LAST)), 8'($urandom));
        2: begin
          c = '{$urandom, $urandom, $urandom, $urandom};
          send(spts_pkg::REQ_HEADER, 8'($urandom),
               ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom), c);
          subtree(0, 3);
        end
        3: begin
          random_header();
          event_only(spts_pkg::REQ_OPEN, 8'($urandom));
          event_only(spts_pkg::REQ_LEAF, 8'($urandom));
          event_only(spts_pkg::REQ_CLOSE, 8'($urandom));
        end
        4: event_only(spts_pkg::REQ_CLOSE, 8'($urandom));
        5: event_only(spts_pkg::REQ_LEAF, 8'($urandom_range(1, 15)));
        default: begin
          random_header();
          subtree(0, $urandom_range(1, 5));
        end
      endcase
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(spts_pkg::cfg_idx_t idx, logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  initial begin
    logic [31:0] c [4];
    logic [63:0] offsets [4];
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no header yet, every operation, field extremes, faults.
    event_only(spts_pkg::REQ_LEAF, 8'h0F);
    event_only(spts_pkg::REQ_CLOSE, 8'h00);
    event_only(spts_pkg::REQ_LEAF, 8'h05);
    event_only(REQ_UNUSED, 8'hFF);
    event_only(REQ_UNUSED_LAST, 8'hFF);
    c = '{32'hFFFF_FFFF, 0, 0, 0};
    header(c);
    event_only(spts_pkg::REQ_OPEN, 8'h00);
    event_only(spts_pkg::REQ_LEAF, 8'h01);
    event_only(spts_pkg::REQ_LEAF, 8'h08);
    event_only(spts_pkg::REQ_CLOSE, 8'h00);
    c = '{0, 0, 0, 32'hFFFF_FFFF};
    header(c);
    event_only(spts_pkg::REQ_LEAF, 8'hF1);
    c = '{1, 2, 3, 4};
    send(spts_pkg::REQ_HEADER, 8'h00, 32'd0, c);
    event_only(spts_pkg::REQ_LEAF, 8'h00);
    header(c);
    event_only(spts_pkg::REQ_OPEN, 8'h00);
    event_only(spts_pkg::REQ_LEAF, 8'h02);
    event_only(spts_pkg::REQ_CLOSE, 8'h00);
    event_only(spts_pkg::REQ_CLEAR, 8'h00);
    // One stack overflow.
    header(c);
    repeat (DEPTH + 1) event_only(spts_pkg::REQ_OPEN, 8'($urandom));
    event_only(spts_pkg::REQ_LEAF, 8'h04);
    repeat (DEPTH) event_only(spts_pkg::REQ_CLOSE, 8'($urandom));
    settle();

    offsets = '{64'd0, '1, 64'hFFFF_FFFF_FFFF_FF00, {$urandom, $urandom}};
    for (int ph = 0; ph < 8; ph++) begin
      sender_idles    = 0;
      receiver_stalls = 0;
      idle_pct        = 59;
      write_reg(spts_pkg::CFG_EDGE_MODE, {$urandom, 31'd0, ph[0]});
      write_reg(spts_pkg::CFG_OFFSET, offsets[(ph / 2) % 4]);
      case (ph % 4)
        1: sender_idles = 1;
        2: receiver_stalls = 1;
        3: begin
          idle_pct        = 24;
          sender_idles    = 1;
          receiver_stalls = 1;
        end
        default: ;
      endcase
      event_only(spts_pkg::REQ_CLEAR, 8'($urandom));
      if (ph == 4) hold_off = 400;
      random_traffic(ph == 3 ? 80 : 160);
      // A stretch without idling inside the idling phases.
      sender_idles    = 0;
      receiver_stalls = 0;
      random_traffic(20);
      settle();
    end

    if (sb.fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/spts_pkg.sv
hw/rtl/spts_front.sv
hw/rtl/spts_fifo.sv
hw/rtl/spts_back.sv
hw/rtl/spts_score.sv
hw/rtl/sankoff_parsimony_tree_scorer_top.sv
dv/sankoff_parsimony_tree_scorer_top_tb.sv
